>>> src/aarm_pkg.sv
`default_nettype none

package aarm_pkg;

  localparam int CORDIC_STAGES_DEF  = 16;
  localparam int ELEM_FRAC_BITS_DEF = 14;
  localparam int MAX_STAGES         = 24;

  // Q2.30 datapath words
  typedef logic signed [32:0] cq_t;
  typedef logic signed [31:0] unit_t;
  typedef logic signed [33:0] prod_t;

  localparam cq_t INV_GAIN_Q30 = 33'sd652032874;
  localparam cq_t ONE_Q30      = 33'sd1073741824;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd843314857;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043837;
      5'd3:    v = 30'd133525159;
      5'd4:    v = 30'd67021687;
      5'd5:    v = 30'd33543516;
      5'd6:    v = 30'd16775851;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194283;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048576;
      5'd11:   v = 30'd524288;
      5'd12:   v = 30'd262144;
      5'd13:   v = 30'd131072;
      5'd14:   v = 30'd65536;
      5'd15:   v = 30'd32768;
      5'd16:   v = 30'd16384;
      5'd17:   v = 30'd8192;
      5'd18:   v = 30'd4096;
      5'd19:   v = 30'd2048;
      5'd20:   v = 30'd1024;
      5'd21:   v = 30'd512;
      5'd22:   v = 30'd256;
      5'd23:   v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Q2.30 product, round half up
  function automatic logic signed [35:0] mul_q30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b;
    p = p + 68'sd536870912;
    return 36'(p >>> 30);
  endfunction

endpackage

`default_nettype wire

>>> src/aarm_cordic.sv
`default_nettype none

module aarm_cordic #(
  parameter int STAGES = aarm_pkg::CORDIC_STAGES_DEF,
  parameter int SB_W   = 1
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              en,
  input  wire              in_valid,
  input  aarm_pkg::cq_t    in_z,
  input  wire [SB_W-1:0]   in_sb,
  output logic             out_valid,
  output aarm_pkg::cq_t    out_x,
  output aarm_pkg::cq_t    out_y,
  output logic [SB_W-1:0]  out_sb
);

  localparam int NSTG = (STAGES < aarm_pkg::MAX_STAGES) ? STAGES : aarm_pkg::MAX_STAGES;

  aarm_pkg::cq_t   x_r [NSTG];
  aarm_pkg::cq_t   y_r [NSTG];
  aarm_pkg::cq_t   z_r [NSTG];
  logic [SB_W-1:0] sb_r [NSTG];
  logic [NSTG-1:0] v_r;

  aarm_pkg::cq_t   x_in [NSTG];
  aarm_pkg::cq_t   y_in [NSTG];
  aarm_pkg::cq_t   z_in [NSTG];
  logic [SB_W-1:0] sb_in [NSTG];
  aarm_pkg::cq_t   x_nxt [NSTG];
  aarm_pkg::cq_t   y_nxt [NSTG];
  aarm_pkg::cq_t   z_nxt [NSTG];

  always_comb begin
    x_in[0]  = aarm_pkg::INV_GAIN_Q30;
    y_in[0]  = '0;
    z_in[0]  = in_z;
    sb_in[0] = in_sb;
    for (int i = 1; i < NSTG; i++) begin
      x_in[i]  = x_r[i-1];
      y_in[i]  = y_r[i-1];
      z_in[i]  = z_r[i-1];
      sb_in[i] = sb_r[i-1];
    end
    // one micro-rotation per stage, direction from the residual angle sign
    for (int i = 0; i < NSTG; i++) begin
      if (!z_in[i][32]) begin
        x_nxt[i] = x_in[i] - (y_in[i] >>> i);
        y_nxt[i] = y_in[i] + (x_in[i] >>> i);
        z_nxt[i] = z_in[i] - 33'({3'b000, aarm_pkg::atan_q30(5'(i))});
      end else begin
        x_nxt[i] = x_in[i] + (y_in[i] >>> i);
        y_nxt[i] = y_in[i] - (x_in[i] >>> i);
        z_nxt[i] = z_in[i] + 33'({3'b000, aarm_pkg::atan_q30(5'(i))});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NSTG; i++) begin
        x_r[i]  <= x_nxt[i];
        y_r[i]  <= y_nxt[i];
        z_r[i]  <= z_nxt[i];
        sb_r[i] <= sb_in[i];
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_x     = x_r[NSTG-1];
  assign out_y     = y_r[NSTG-1];
  assign out_sb    = sb_r[NSTG-1];

endmodule

`default_nettype wire

>>> src/aarm_norm.sv
`default_nettype none

module aarm_norm #(
  parameter int SB_W = 1
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                en,
  input  wire                in_valid,
  input  wire [31:0]         in_len2,
  input  wire [2:0][15:0]    in_axis,
  input  wire [SB_W-1:0]     in_sb,
  output logic               out_valid,
  output aarm_pkg::unit_t    out_ux,
  output aarm_pkg::unit_t    out_uy,
  output aarm_pkg::unit_t    out_uz,
  output logic [SB_W-1:0]    out_sb
);

  localparam int SQ = 30;
  localparam int DV = 31;

  // square root, one result bit per stage
  logic [59:0]       rem_r [SQ];
  logic [60:0]       res_r [SQ];
  logic [2:0][15:0]  sa_r  [SQ];
  logic [SB_W-1:0]   ssb_r [SQ];
  logic [SQ-1:0]     sv_r;

  logic [59:0]       rem_in [SQ];
  logic [60:0]       res_in [SQ];
  logic [2:0][15:0]  sa_in  [SQ];
  logic [SB_W-1:0]   ssb_in [SQ];
  logic [59:0]       rem_nxt [SQ];
  logic [60:0]       res_nxt [SQ];

  always_comb begin
    logic [60:0] bitv;
    logic [60:0] sum;
    rem_in[0] = 60'(in_len2) << 28;
    res_in[0] = '0;
    sa_in[0]  = in_axis;
    ssb_in[0] = in_sb;
    for (int k = 1; k < SQ; k++) begin
      rem_in[k] = rem_r[k-1];
      res_in[k] = res_r[k-1];
      sa_in[k]  = sa_r[k-1];
      ssb_in[k] = ssb_r[k-1];
    end
    for (int k = 0; k < SQ; k++) begin
      bitv = 61'(1) << (58 - 2 * k);
      sum  = res_in[k] + bitv;
      if ({1'b0, rem_in[k]} >= sum) begin
        rem_nxt[k] = 60'({1'b0, rem_in[k]} - sum);
        res_nxt[k] = (res_in[k] >> 1) + bitv;
      end else begin
        rem_nxt[k] = rem_in[k];
        res_nxt[k] = res_in[k] >> 1;
      end
    end
  end

  // restoring division of the three magnitudes, one quotient bit per stage
  logic [29:0]       r_r  [DV][3];
  logic [30:0]       q_r  [DV][3];
  logic [30:0]       dl_r [DV][3];
  logic [29:0]       n_r  [DV];
  logic [2:0]        sg_r [DV];
  logic [SB_W-1:0]   dsb_r [DV];
  logic [DV-1:0]     dv_r;

  logic [29:0]       r_in  [DV][3];
  logic [30:0]       q_in  [DV][3];
  logic [30:0]       dl_in [DV][3];
  logic [29:0]       n_in  [DV];
  logic [2:0]        sg_in [DV];
  logic [SB_W-1:0]   dsb_in [DV];
  logic [29:0]       r_nxt [DV][3];
  logic [30:0]       q_nxt [DV][3];

  always_comb begin
    logic [15:0] mag;
    logic [59:0] dvd;
    logic [30:0] rr;
    n_in[0]   = res_r[SQ-1][29:0];
    dsb_in[0] = ssb_r[SQ-1];
    for (int l = 0; l < 3; l++) begin
      sg_in[0][l] = sa_r[SQ-1][l][15];
      mag = sa_r[SQ-1][l][15] ? 16'(-sa_r[SQ-1][l]) : sa_r[SQ-1][l];
      dvd = (60'(mag) << 44) + 60'(res_r[SQ-1][29:1]);
      r_in[0][l]  = {1'b0, dvd[59:31]};
      dl_in[0][l] = dvd[30:0];
      q_in[0][l]  = '0;
    end
    for (int j = 1; j < DV; j++) begin
      n_in[j]   = n_r[j-1];
      sg_in[j]  = sg_r[j-1];
      dsb_in[j] = dsb_r[j-1];
      for (int l = 0; l < 3; l++) begin
        r_in[j][l]  = r_r[j-1][l];
        q_in[j][l]  = q_r[j-1][l];
        dl_in[j][l] = dl_r[j-1][l] << 1;
      end
    end
    for (int j = 0; j < DV; j++) begin
      for (int l = 0; l < 3; l++) begin
        rr = {r_in[j][l], dl_in[j][l][30]};
        if (rr >= {1'b0, n_in[j]}) begin
          r_nxt[j][l] = 30'(rr - {1'b0, n_in[j]});
          q_nxt[j][l] = {q_in[j][l][29:0], 1'b1};
        end else begin
          r_nxt[j][l] = rr[29:0];
          q_nxt[j][l] = {q_in[j][l][29:0], 1'b0};
        end
      end
    end
  end

  aarm_pkg::unit_t u_r [3];
  logic [SB_W-1:0] osb_r;
  logic            ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
      dv_r <= '0;
      ov_r <= 1'b0;
    end else if (en) begin
      sv_r <= {sv_r[SQ-2:0], in_valid};
      dv_r <= {dv_r[DV-2:0], sv_r[SQ-1]};
      ov_r <= dv_r[DV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ; k++) begin
        rem_r[k] <= rem_nxt[k];
        res_r[k] <= res_nxt[k];
        sa_r[k]  <= sa_in[k];
        ssb_r[k] <= ssb_in[k];
      end
      for (int j = 0; j < DV; j++) begin
        n_r[j]   <= n_in[j];
        sg_r[j]  <= sg_in[j];
        dsb_r[j] <= dsb_in[j];
        for (int l = 0; l < 3; l++) begin
          r_r[j][l]  <= r_nxt[j][l];
          q_r[j][l]  <= q_nxt[j][l];
          dl_r[j][l] <= dl_in[j][l];
        end
      end
      for (int l = 0; l < 3; l++) begin
        u_r[l] <= sg_r[DV-1][l] ? -$signed({1'b0, q_r[DV-1][l]})
                                :  $signed({1'b0, q_r[DV-1][l]});
      end
      osb_r <= dsb_r[DV-1];
    end
  end

  assign out_valid = ov_r;
  assign out_ux    = u_r[0];
  assign out_uy    = u_r[1];
  assign out_uz    = u_r[2];
  assign out_sb    = osb_r;

endmodule

`default_nettype wire

>>> src/axis_angle_rotation_matrix.sv
`default_nettype none

// Axis-angle to 3x3 rotation matrix (Rodrigues form).
// Input channel: in_angle_deg (signed Q16.16 degrees) and in_axis_x/y/z
// (signed, any nonzero length), taken when in_valid and in_ready are high.
// Result channel: out_rot_xx .. out_rot_zz in row order, signed with
// ELEM_FRAC_BITS fraction bits and saturated to 16 bits, plus out_zero_axis,
// which flags an all-zero axis; that item returns the identity.
// Pipeline: three angle-reduction stages, one stage per CORDIC rotation
// (rotations are capped at 24; 16 by default), 30 square-root stages, 31
// divider stages, one stage each to undo the fold and to sign the unit
// axis, and three product and output stages. Throughput: one item per
// cycle while the output is not stalled; every stage is registered and a
// new item can enter each cycle that the pipeline advances.
// Backpressure: the whole pipeline advances only while the output register
// is empty or being taken, so a stalled receiver holds every stage in place
// and in_ready drops in the same cycle; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; the data
// registers are not reset.
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STAGES  = aarm_pkg::CORDIC_STAGES_DEF,
  parameter int ELEM_FRAC_BITS = aarm_pkg::ELEM_FRAC_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire signed [31:0]  in_angle_deg,
  input  wire signed [15:0]  in_axis_x,
  input  wire signed [15:0]  in_axis_y,
  input  wire signed [15:0]  in_axis_z,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [15:0] out_rot_xx,
  output logic signed [15:0] out_rot_xy,
  output logic signed [15:0] out_rot_xz,
  output logic signed [15:0] out_rot_yx,
  output logic signed [15:0] out_rot_yy,
  output logic signed [15:0] out_rot_yz,
  output logic signed [15:0] out_rot_zx,
  output logic signed [15:0] out_rot_zy,
  output logic signed [15:0] out_rot_zz,
  output logic               out_zero_axis
);

  localparam int SH = 30 - ELEM_FRAC_BITS;
  localparam logic [15:0] ONE_OUT = (ELEM_FRAC_BITS >= 15) ? 16'h7fff
                                    : 16'(1 << ELEM_FRAC_BITS);

  // angle constants in Q16.16 degrees; DEG_TO_RAD is pi/180 in Q2.30
  localparam logic signed [25:0] FULL_TURN    = 26'sd23592960;
  localparam logic signed [25:0] HALF_TURN    = 26'sd11796480;
  localparam logic signed [25:0] QUARTER_TURN = 26'sd5898240;
  localparam logic signed [25:0] DEG_TO_RAD   = 26'sd18740330;
  // offset that makes the integer degrees nonnegative (92 turns)
  localparam logic signed [17:0] DEG_OFFSET   = 18'sd33120;
  // ceil(2^25 / 360) for the quotient estimate
  localparam logic [33:0]        RECIP_360    = 34'd93207;

  localparam int CSB_W = 32 + 48 + 2;
  localparam int NSB_W = 33 + 33 + 1;

  // The whole pipeline moves together: advance whenever the output register
  // can take a new item.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- S1: quotient estimate of integer degrees / 360 --------
  logic [17:0] deg_off;
  logic [33:0] qprod;
  logic        v1_r;
  logic [16:0] deg1_r;
  logic [7:0]  q1_r;
  logic [15:0] lo1_r;
  logic [2:0][15:0] a1_r;
  logic        zero1_r;

  assign deg_off = 18'($signed(in_angle_deg[31:16])) + DEG_OFFSET;
  assign qprod   = 34'(deg_off[16:0]) * RECIP_360;

  always_ff @(posedge clk) begin
    if (en) begin
      deg1_r  <= deg_off[16:0];
      q1_r    <= qprod[32:25];
      lo1_r   <= in_angle_deg[15:0];
      a1_r    <= {in_axis_z, in_axis_y, in_axis_x};
      zero1_r <= (in_axis_x == 16'sd0) && (in_axis_y == 16'sd0) && (in_axis_z == 16'sd0);
    end
  end

  // ---------------- S2: remainder, fold into [-90, 90], axis squares -----
  logic [8:0]         rem_deg;
  logic signed [25:0] r_full;
  logic signed [25:0] r_fold;
  logic               neg_fold;
  logic [2:0][30:0]   sq;
  logic               v2_r;
  logic signed [23:0] r2_r;
  logic               neg2_r;
  logic [2:0][30:0]   sq2_r;
  logic [2:0][15:0]   a2_r;
  logic               zero2_r;

  always_comb begin
    logic signed [31:0] p;
    rem_deg = 9'(deg1_r - 17'(q1_r) * 17'd360);
    r_full  = $signed({1'b0, rem_deg, lo1_r});
    if (r_full >= HALF_TURN) begin
      r_full = r_full - FULL_TURN;
    end
    neg_fold = 1'b0;
    r_fold   = r_full;
    if (r_full > QUARTER_TURN) begin
      r_fold   = r_full - HALF_TURN;
      neg_fold = 1'b1;
    end else if (r_full < -QUARTER_TURN) begin
      r_fold   = r_full + HALF_TURN;
      neg_fold = 1'b1;
    end
    for (int l = 0; l < 3; l++) begin
      p     = $signed(a1_r[l]) * $signed(a1_r[l]);
      sq[l] = p[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r    <= r_fold[23:0];
      neg2_r  <= neg_fold;
      sq2_r   <= sq;
      a2_r    <= a1_r;
      zero2_r <= zero1_r;
    end
  end

  // ---------------- S3: degrees to Q2.30 radians, squared length ---------
  logic signed [49:0] rad_prod;
  logic signed [33:0] rad_q30;
  logic               v3_r;
  aarm_pkg::cq_t      z3_r;
  logic [31:0]        len2_3_r;
  logic [2:0][15:0]   a3_r;
  logic               neg3_r;
  logic               zero3_r;

  assign rad_prod = 50'(r2_r) * 50'(DEG_TO_RAD);
  assign rad_q30  = 34'((rad_prod + 50'sd32768) >>> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      z3_r     <= rad_q30[32:0];
      len2_3_r <= 32'(sq2_r[0]) + 32'(sq2_r[1]) + 32'(sq2_r[2]);
      a3_r     <= a2_r;
      neg3_r   <= neg2_r;
      zero3_r  <= zero2_r;
    end
  end

  // ---------------- CORDIC rotation ---------------------------------------
  logic              cv;
  aarm_pkg::cq_t     cx;
  aarm_pkg::cq_t     cy;
  logic [CSB_W-1:0]  csb;

  aarm_cordic #(
    .STAGES (CORDIC_STAGES),
    .SB_W   (CSB_W)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_z      (z3_r),
    .in_sb     ({len2_3_r, a3_r, zero3_r, neg3_r}),
    .out_valid (cv),
    .out_x     (cx),
    .out_y     (cy),
    .out_sb    (csb)
  );

  // ---------------- S4: undo the half-turn fold ---------------------------
  logic             v4_r;
  aarm_pkg::cq_t    c4_r;
  aarm_pkg::cq_t    s4_r;
  logic [31:0]      len2_4_r;
  logic [2:0][15:0] a4_r;
  logic             zero4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c4_r     <= csb[0] ? -cx : cx;
      s4_r     <= csb[0] ? -cy : cy;
      len2_4_r <= csb[CSB_W-1 -: 32];
      a4_r     <= csb[49:2];
      zero4_r  <= csb[1];
    end
  end

  // ---------------- axis normalization ------------------------------------
  logic             nv;
  aarm_pkg::unit_t  ux;
  aarm_pkg::unit_t  uy;
  aarm_pkg::unit_t  uz;
  logic [NSB_W-1:0] nsb;

  aarm_norm #(
    .SB_W (NSB_W)
  ) u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .in_len2   (len2_4_r),
    .in_axis   (a4_r),
    .in_sb     ({c4_r, s4_r, zero4_r}),
    .out_valid (nv),
    .out_ux    (ux),
    .out_uy    (uy),
    .out_uz    (uz),
    .out_sb    (nsb)
  );

  aarm_pkg::cq_t n_c;
  aarm_pkg::cq_t n_s;
  assign n_c = nsb[66:34];
  assign n_s = nsb[33:1];

  // ---------------- P1: outer products u*u^T and u*sin -------------------
  logic           vp1_r;
  aarm_pkg::prod_t uu_r [6];   // xx, xy, xz, yy, yz, zz
  aarm_pkg::prod_t us_r [3];   // x, y, z times sin
  aarm_pkg::cq_t  t1_r;
  aarm_pkg::cq_t  c1_r;
  logic           zp1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      uu_r[0] <= 34'(aarm_pkg::mul_q30(34'(ux), 34'(ux)));
      uu_r[1] <= 34'(aarm_pkg::mul_q30(34'(ux), 34'(uy)));
      uu_r[2] <= 34'(aarm_pkg::mul_q30(34'(ux), 34'(uz)));
      uu_r[3] <= 34'(aarm_pkg::mul_q30(34'(uy), 34'(uy)));
      uu_r[4] <= 34'(aarm_pkg::mul_q30(34'(uy), 34'(uz)));
      uu_r[5] <= 34'(aarm_pkg::mul_q30(34'(uz), 34'(uz)));
      us_r[0] <= 34'(aarm_pkg::mul_q30(34'(ux), 34'(n_s)));
      us_r[1] <= 34'(aarm_pkg::mul_q30(34'(uy), 34'(n_s)));
      us_r[2] <= 34'(aarm_pkg::mul_q30(34'(uz), 34'(n_s)));
      t1_r    <= aarm_pkg::ONE_Q30 - n_c;
      c1_r    <= n_c;
      zp1_r   <= nsb[0];
    end
  end

  // ---------------- P2: scale by (1 - cos) --------------------------------
  logic            vp2_r;
  aarm_pkg::prod_t ut_r [6];
  aarm_pkg::prod_t us2_r [3];
  aarm_pkg::cq_t   c2_r;
  logic            zp2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        ut_r[k] <= 34'(aarm_pkg::mul_q30(uu_r[k], 34'(t1_r)));
      end
      for (int k = 0; k < 3; k++) begin
        us2_r[k] <= us_r[k];
      end
      c2_r  <= c1_r;
      zp2_r <= zp1_r;
    end
  end

  // ---------------- P3: sum, round, saturate into the output register ----
  function automatic logic [15:0] to_out(input logic signed [35:0] v);
    logic signed [36:0] w;
    logic [15:0]        o;
    w = (37'(v) + (37'sd1 <<< (SH - 1))) >>> SH;
    if (w > 37'sd32767) begin
      o = 16'h7fff;
    end else if (w < -37'sd32768) begin
      o = 16'h8000;
    end else begin
      o = w[15:0];
    end
    return o;
  endfunction

  logic signed [35:0] m [9];
  logic [15:0]        rot_nxt [9];
  logic [15:0]        rot_r [9];
  logic               zero_r;

  always_comb begin
    m[0] = 36'(c2_r) + 36'(ut_r[0]);
    m[1] = 36'(ut_r[1]) - 36'(us2_r[2]);
    m[2] = 36'(ut_r[2]) + 36'(us2_r[1]);
    m[3] = 36'(ut_r[1]) + 36'(us2_r[2]);
    m[4] = 36'(c2_r) + 36'(ut_r[3]);
    m[5] = 36'(ut_r[4]) - 36'(us2_r[0]);
    m[6] = 36'(ut_r[2]) - 36'(us2_r[1]);
    m[7] = 36'(ut_r[4]) + 36'(us2_r[0]);
    m[8] = 36'(c2_r) + 36'(ut_r[5]);
    for (int k = 0; k < 9; k++) begin
      // zero-length axis: identity
      if (zp2_r) begin
        rot_nxt[k] = (k % 4 == 0) ? ONE_OUT : 16'h0000;
      end else begin
        rot_nxt[k] = to_out(m[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        rot_r[k] <= rot_nxt[k];
      end
      zero_r <= zp2_r;
    end
  end

  // ---------------- valid chain around the submodules ---------------------
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      vp1_r       <= 1'b0;
      vp2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= cv;
      vp1_r       <= nv;
      vp2_r       <= vp1_r;
      out_valid_r <= vp2_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rot_xx    = rot_r[0];
  assign out_rot_xy    = rot_r[1];
  assign out_rot_xz    = rot_r[2];
  assign out_rot_yx    = rot_r[3];
  assign out_rot_yy    = rot_r[4];
  assign out_rot_yz    = rot_r[5];
  assign out_rot_zx    = rot_r[6];
  assign out_rot_zy    = rot_r[7];
  assign out_rot_zz    = rot_r[8];
  assign out_zero_axis = zero_r;

`ifndef SYNTHESIS
  // a zero axis always leaves as the identity
  a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_axis |-> out_rot_xx == ONE_OUT && out_rot_yy == ONE_OUT
      && out_rot_zz == ONE_OUT && out_rot_xy == 16'sd0 && out_rot_zy == 16'sd0)
    else $error("zero axis item is not the identity");

  // a stall freezes the pipeline: the next output valid cannot change
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> out_valid == $past(out_valid) && vp2_r == $past(vp2_r))
    else $error("pipeline moved during a stall");

  // nothing enters while the output register is blocked
  a_ready_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output blocked");
`endif

endmodule

`default_nettype wire
